// ----- design/dcfm_pkg.sv -----
// Shared types and constants for the dual-channel capture frequency meter.
// No dependencies; every other design file imports this package.
package dcfm_pkg;

  localparam int CAPTURE_WIDTH = 16;
  localparam int DIV_W         = 32;
  localparam int WEIGHT_W      = 17;
  localparam int WRAP_W        = 16;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [WRAP_W-1:0] WRAP_MAX = '1;

  // Register reset values
  localparam logic [DIV_W-1:0]    CLOCK_HZ_RST = 32'd72000000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 17'd65535;
  localparam logic [WRAP_W-1:0]   TIMEOUT_RST  = 16'd6;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_CLOCK_HZ = 2'd0;
  localparam logic [1:0] REG_WEIGHT   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  // Per-channel operation for the back end
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_ZERO = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  typedef struct packed {
    logic                     overflow_event;
    logic                     capture_a_valid;
    logic [CAPTURE_WIDTH-1:0] capture_a_value;
    logic                     capture_b_valid;
    logic [CAPTURE_WIDTH-1:0] capture_b_value;
  } dcfm_in_t;

  typedef struct packed {
    logic [DIV_W-1:0] freq_a;
    logic [DIV_W-1:0] freq_b;
  } dcfm_out_t;

  typedef struct packed {
    logic [DIV_W-1:0]    clock_hz;
    logic [WEIGHT_W-1:0] overflow_weight;
    logic [WRAP_W-1:0]   timeout_overflows;
  } dcfm_cfg_t;

  typedef struct packed {
    logic [1:0]       op_a;
    logic [DIV_W-1:0] period_a;
    logic [1:0]       op_b;
    logic [DIV_W-1:0] period_b;
  } dcfm_job_t;

endpackage

// ----- design/dcfm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on dcfm_pkg for the operand width.
module dcfm_div import dcfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dvs_r;

  logic [DIV_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        cnt_r  <= CNT_W'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // restore or keep the trial subtraction
      rem_r <= ge ? DIV_W'(shifted - {1'b0, dvs_r}) : shifted[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/dcfm_fifo.sv -----
// Small register queue between the front and back ends.
// Depends on dcfm_pkg for the job type.
module dcfm_fifo import dcfm_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  dcfm_job_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output dcfm_job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dcfm_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/dcfm_front.sv -----
// Front end: accept items, track capture phase and overflow counts,
// form periods and classify each channel's update. Depends on dcfm_pkg.
module dcfm_front import dcfm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dcfm_cfg_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  dcfm_in_t  in_data,
  output logic      job_valid,
  input  logic      job_ready,
  output dcfm_job_t job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_OVF  = 2'd1;
  localparam logic [1:0] F_MUL  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  typedef struct packed {
    logic                     phase;
    logic [CAPTURE_WIDTH-1:0] first;
    logic [WRAP_W-1:0]        wraps;
    logic [1:0]               op;
    logic [DIV_W-1:0]         period;
  } chan_upd_t;

  function automatic chan_upd_t chan_next(
    input logic                     phase,
    input logic [CAPTURE_WIDTH-1:0] first,
    input logic [WRAP_W-1:0]        wraps,
    input logic                     tmo,
    input logic                     cap_valid,
    input logic [CAPTURE_WIDTH-1:0] cap_value,
    input logic [DIV_W-1:0]         prod
  );
    chan_upd_t        u;
    logic [DIV_W-1:0] period;
    period   = prod - DIV_W'(first) + DIV_W'(cap_value);
    u.phase  = phase;
    u.first  = first;
    u.wraps  = wraps;
    u.period = period;
    u.op     = tmo ? OP_ZERO : OP_HOLD;
    if (cap_valid) begin
      if (!phase) begin
        u.phase = 1'b1;
        u.first = cap_value;
        u.wraps = '0;
      end else begin
        u.phase = 1'b0;
        u.op    = (period == '0) ? OP_ZERO : OP_DIV;
      end
    end
    return u;
  endfunction

  logic [1:0]               fstate_r;
  logic [1:0]               fstate_nxt;
  dcfm_in_t                 item_r;
  logic                     phase_a_r;
  logic                     phase_b_r;
  logic [CAPTURE_WIDTH-1:0] first_a_r;
  logic [CAPTURE_WIDTH-1:0] first_b_r;
  logic [WRAP_W-1:0]        wraps_a_r;
  logic [WRAP_W-1:0]        wraps_b_r;
  logic                     tmo_a_r;
  logic                     tmo_b_r;
  logic [DIV_W-1:0]         prod_a_r;
  logic [DIV_W-1:0]         prod_b_r;

  logic [WRAP_W-1:0]          wraps_a_inc;
  logic [WRAP_W-1:0]          wraps_b_inc;
  logic [WEIGHT_W+WRAP_W-1:0] prod_a_full;
  logic [WEIGHT_W+WRAP_W-1:0] prod_b_full;
  chan_upd_t                  upd_a;
  chan_upd_t                  upd_b;

  assign wraps_a_inc = (wraps_a_r == WRAP_MAX) ? wraps_a_r : wraps_a_r + 1'b1;
  assign wraps_b_inc = (wraps_b_r == WRAP_MAX) ? wraps_b_r : wraps_b_r + 1'b1;
  assign prod_a_full = cfg.overflow_weight * wraps_a_r;
  assign prod_b_full = cfg.overflow_weight * wraps_b_r;

  assign upd_a = chan_next(phase_a_r, first_a_r, wraps_a_r, tmo_a_r,
                           item_r.capture_a_valid, item_r.capture_a_value, prod_a_r);
  assign upd_b = chan_next(phase_b_r, first_b_r, wraps_b_r, tmo_b_r,
                           item_r.capture_b_valid, item_r.capture_b_value, prod_b_r);

  assign in_ready  = fstate_r == F_IDLE;
  assign job_valid = fstate_r == F_PUSH;
  assign job       = '{op_a: upd_a.op, period_a: upd_a.period,
                       op_b: upd_b.op, period_b: upd_b.period};

  always_comb begin
    fstate_nxt = fstate_r;
    case (fstate_r)
      F_IDLE:  if (in_valid) fstate_nxt = F_OVF;
      F_OVF:   fstate_nxt = F_MUL;
      F_MUL:   fstate_nxt = F_PUSH;
      F_PUSH:  if (job_ready) fstate_nxt = F_IDLE;
      default: fstate_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r  <= F_IDLE;
      phase_a_r <= 1'b0;
      phase_b_r <= 1'b0;
      first_a_r <= '0;
      first_b_r <= '0;
      wraps_a_r <= '0;
      wraps_b_r <= '0;
    end else begin
      fstate_r <= fstate_nxt;
      if (fstate_r == F_OVF && item_r.overflow_event) begin
        wraps_a_r <= wraps_a_inc;
        wraps_b_r <= wraps_b_inc;
      end
      if (fstate_r == F_PUSH && job_ready) begin
        phase_a_r <= upd_a.phase;
        first_a_r <= upd_a.first;
        wraps_a_r <= upd_a.wraps;
        phase_b_r <= upd_b.phase;
        first_b_r <= upd_b.first;
        wraps_b_r <= upd_b.wraps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fstate_r == F_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (fstate_r == F_OVF) begin
      // timeout is judged only on the item that brings an overflow
      tmo_a_r <= item_r.overflow_event && (wraps_a_inc > cfg.timeout_overflows);
      tmo_b_r <= item_r.overflow_event && (wraps_b_inc > cfg.timeout_overflows);
    end
    if (fstate_r == F_MUL) begin
      prod_a_r <= prod_a_full[DIV_W-1:0];
      prod_b_r <= prod_b_full[DIV_W-1:0];
    end
  end

endmodule

// ----- design/dcfm_back.sv -----
// Back end: apply queued channel updates through the shared divider
// and present results from an output register. Depends on dcfm_pkg, dcfm_div.
module dcfm_back import dcfm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dcfm_cfg_t cfg,
  input  logic      job_valid,
  output logic      job_ready,
  input  dcfm_job_t job,
  output logic      out_valid,
  input  logic      out_ready,
  output dcfm_out_t out_data
);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_A      = 3'd1;
  localparam logic [2:0] B_A_WAIT = 3'd2;
  localparam logic [2:0] B_B      = 3'd3;
  localparam logic [2:0] B_B_WAIT = 3'd4;
  localparam logic [2:0] B_OUT    = 3'd5;

  logic [2:0]       bstate_r;
  logic [2:0]       bstate_nxt;
  dcfm_job_t        job_r;
  logic [DIV_W-1:0] freq_a_r;
  logic [DIV_W-1:0] freq_b_r;
  logic             out_valid_r;
  dcfm_out_t        out_data_r;

  logic             div_start;
  logic [DIV_W-1:0] div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  logic             out_load;

  assign job_ready   = bstate_r == B_IDLE;
  assign div_start   = (bstate_r == B_A && job_r.op_a == OP_DIV) ||
                       (bstate_r == B_B && job_r.op_b == OP_DIV);
  assign div_divisor = (bstate_r == B_A) ? job_r.period_a : job_r.period_b;
  assign out_load    = bstate_r == B_OUT && (!out_valid_r || out_ready);

  dcfm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfg.clock_hz),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    bstate_nxt = bstate_r;
    case (bstate_r)
      B_IDLE:   if (job_valid) bstate_nxt = B_A;
      B_A:      bstate_nxt = (job_r.op_a == OP_DIV) ? B_A_WAIT : B_B;
      B_A_WAIT: if (div_done && !div_busy) bstate_nxt = B_B;
      B_B:      bstate_nxt = (job_r.op_b == OP_DIV) ? B_B_WAIT : B_OUT;
      B_B_WAIT: if (div_done && !div_busy) bstate_nxt = B_OUT;
      B_OUT:    if (out_load) bstate_nxt = B_IDLE;
      default:  bstate_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      freq_a_r    <= '0;
      freq_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r <= bstate_nxt;
      if (bstate_r == B_A && job_r.op_a == OP_ZERO) begin
        freq_a_r <= '0;
      end
      if (bstate_r == B_A_WAIT && div_done) begin
        freq_a_r <= div_quot;
      end
      if (bstate_r == B_B && job_r.op_b == OP_ZERO) begin
        freq_b_r <= '0;
      end
      if (bstate_r == B_B_WAIT && div_done) begin
        freq_b_r <= div_quot;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bstate_r == B_IDLE && job_valid) begin
      job_r <= job;
    end
    if (out_load) begin
      out_data_r <= '{freq_a: freq_a_r, freq_b: freq_b_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/dual_channel_capture_freq_meter_unit.sv -----
// Top level of the dual-channel capture frequency meter: register file,
// front end, job queue and back end. Depends on dcfm_pkg and dcfm_front/fifo/back.
//
// Each accepted input beat carries an optional counter overflow and an optional
// capture on channels A and B; every beat yields exactly one output beat with
// both channels' current frequencies in hertz. The front end steps through each
// beat (accept, count overflow and test timeout, multiply weight by overflow
// count, form the period and hand off the job), then accepts the next beat while
// the back end is still working. The back end applies each job in order: a
// channel that needs a new frequency runs the shared radix-2 divider, clock_hz
// divided by the period, at one quotient bit per cycle, and that divider sets the
// sustained rate whenever edges are dense. The job queue (QUEUE_DEPTH entries)
// lets the front end run ahead by that many beats, and the output register
// holds a finished result while the next beat is already being processed.
// Registers sit on the APB-style port at byte addresses 0 (clock_hz),
// 4 (overflow_weight) and 8 (timeout_overflows); write them only while idle.
module dual_channel_capture_freq_meter_unit import dcfm_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  dcfm_in_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output dcfm_out_t         out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DIV_W-1:0]    clock_hz_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [WRAP_W-1:0]   timeout_r;
  logic [1:0]          reg_idx;
  logic                reg_wr;
  dcfm_cfg_t           cfg;

  logic      job_push_valid;
  logic      job_push_ready;
  dcfm_job_t job_push_data;
  logic      job_pop_valid;
  logic      job_pop_ready;
  dcfm_job_t job_pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  // Written values are trimmed to the register width; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_HZ_RST;
      weight_r   <= WEIGHT_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_CLOCK_HZ: clock_hz_r <= pwdata;
        REG_WEIGHT:   weight_r   <= pwdata[WEIGHT_W-1:0];
        REG_TIMEOUT:  timeout_r  <= pwdata[WRAP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CLOCK_HZ: prdata = clock_hz_r;
      REG_WEIGHT:   prdata = DATA_W'(weight_r);
      REG_TIMEOUT:  prdata = DATA_W'(timeout_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg = '{clock_hz: clock_hz_r, overflow_weight: weight_r,
                 timeout_overflows: timeout_r};

  // Classify beats and form periods
  dcfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_push_valid),
    .job_ready (job_push_ready),
    .job       (job_push_data)
  );

  // Decouple front from the divider
  dcfm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_push_valid),
    .push_ready (job_push_ready),
    .push_data  (job_push_data),
    .pop_valid  (job_pop_valid),
    .pop_ready  (job_pop_ready),
    .pop_data   (job_pop_data)
  );

  // Divide, hold frequencies and drive results
  dcfm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (job_pop_valid),
    .job_ready (job_pop_ready),
    .job       (job_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/dcfm_checker.sv -----
// Port-level checks for the frequency meter top level, attached by bind.
// Depends on dcfm_pkg and dual_channel_capture_freq_meter_unit.
module dcfm_checker import dcfm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input dcfm_out_t out_data
);

  logic [7:0] pend_r;

  // Count beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   pend_r <= pend_r + 1'b1;
        2'b01:   pend_r <= pend_r - 1'b1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without an accepted input beat");

endmodule

bind dual_channel_capture_freq_meter_unit dcfm_checker u_chk (.*);
